// ===== rtl/id_allowlist_table_defines.svh =====
// Assertion macros used by the identifier allowlist table RTL.
`ifndef ID_ALLOWLIST_TABLE_DEFINES_SVH
`define ID_ALLOWLIST_TABLE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define IDAT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("idat assertion failed");

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define IDAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("idat assertion failed");

`endif

// ===== rtl/idat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier allowlist package
// Shared types, codes and size constants for the identifier allowlist tables.
// ----------------------------------------------------------------------------
package idat_pkg;

  localparam int unsigned ORD_SLOTS_DEF  = 128;
  localparam int unsigned PRIV_SLOTS_DEF = 16;
  localparam int unsigned ID_W           = 64;
  localparam int unsigned SLOT_W         = 7;
  localparam int unsigned OCC_W          = 8;
  localparam int unsigned PRIV_FILL_W    = 5;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_DROP   = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_ZERO    = 3'd1,
    STATUS_PRESENT = 3'd2,
    STATUS_FULL    = 3'd3,
    STATUS_ABSENT  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   table_select;
    logic signed [ID_W-1:0] entry_id;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic                hit;
    logic [SLOT_W-1:0]   slot_index;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic              set;
    logic [SLOT_W-1:0] addr;
    logic [ID_W-1:0]   data;
  } wr_cmd_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] data;
  } rd_rsp_t;

endpackage

// ===== rtl/id_allowlist_table.sv =====
`timescale 1ns / 1ps
// An item with a zero identifier goes from IDLE straight to EXEC, skipping the scan.
// Other items pass through SCAN, which reads the selected table's slots one per cycle
// through the table memory, then EXEC; a match ends the scan early.
// Throughput: one item at a time, input stalled from acceptance until the result registers.
// Reset clears both tables at once through per-slot occupied bits; there is no clearing pass.
// ----------------------------------------------------------------------------
// Identifier allowlist table
// Ordinary and privileged identifier tables with add, drop and lookup,
// searched by a sequencer that compares one stored slot per cycle.
// ----------------------------------------------------------------------------
`include "id_allowlist_table_defines.svh"

module id_allowlist_table #(
  parameter int unsigned ORDINARY_SLOTS   = idat_pkg::ORD_SLOTS_DEF,
  parameter int unsigned PRIVILEGED_SLOTS = idat_pkg::PRIV_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  idat_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output idat_pkg::out_item_t out_item_o
);

  idat_pkg::state_e                  state_q, state_d;
  idat_pkg::in_item_t                item_q, item_d;
  logic [idat_pkg::OCC_W-1:0]        cnt_q, cnt_d;
  logic                              pend_q, pend_d;
  logic [idat_pkg::SLOT_W-1:0]       pidx_q, pidx_d;
  logic                              mfound_q, mfound_d;
  logic [idat_pkg::SLOT_W-1:0]       midx_q, midx_d;
  logic                              efound_q, efound_d;
  logic [idat_pkg::SLOT_W-1:0]       eidx_q, eidx_d;
  logic [idat_pkg::OCC_W-1:0]        ord_fill_q, ord_fill_d;
  logic [idat_pkg::PRIV_FILL_W-1:0]  priv_fill_q, priv_fill_d;
  logic                              out_valid_q, out_valid_d;
  idat_pkg::out_item_t               out_q, out_d;

  idat_pkg::rd_rsp_t           ord_rsp, priv_rsp, rsp_sel;
  idat_pkg::wr_cmd_t           wr_cmd, ord_wr, priv_wr;
  idat_pkg::out_item_t         res;
  logic                        wr_want;
  logic [idat_pkg::OCC_W-1:0]  size;
  logic [idat_pkg::OCC_W-1:0]  cur_fill;
  logic                        eq;
  logic                        empty_now;
  logic                        last;
  logic                        issue;
  logic                        out_free;
  logic                        commit;
  logic                        id_zero;

  assign size     = item_q.table_select ? idat_pkg::OCC_W'(PRIVILEGED_SLOTS)
                                        : idat_pkg::OCC_W'(ORDINARY_SLOTS);
  assign cur_fill = item_q.table_select
                    ? {{(idat_pkg::OCC_W-idat_pkg::PRIV_FILL_W){1'b0}}, priv_fill_q}
                    : ord_fill_q;
  assign rsp_sel   = item_q.table_select ? priv_rsp : ord_rsp;
  assign eq        = pend_q && rsp_sel.valid && (rsp_sel.data == $unsigned(item_q.entry_id));
  assign empty_now = pend_q && !rsp_sel.valid;
  assign last      = ({1'b0, pidx_q} == (size - idat_pkg::OCC_W'(1)));
  assign issue     = (state_q == idat_pkg::ST_SCAN) && (cnt_q < size);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign commit    = (state_q == idat_pkg::ST_EXEC) && out_free;
  assign id_zero   = (item_q.entry_id == '0);

  idat_store #(
    .DEPTH (ORDINARY_SLOTS)
  ) u_ord_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (cnt_q[idat_pkg::SLOT_W-1:0]),
    .wr_i      (ord_wr),
    .rsp_o     (ord_rsp)
  );

  idat_store #(
    .DEPTH (PRIVILEGED_SLOTS)
  ) u_priv_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (cnt_q[idat_pkg::SLOT_W-1:0]),
    .wr_i      (priv_wr),
    .rsp_o     (priv_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      idat_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_item_i.entry_id == '0) ? idat_pkg::ST_EXEC : idat_pkg::ST_SCAN;
        end
      end
      idat_pkg::ST_SCAN: begin
        if (eq || (pend_q && last)) begin
          state_d = idat_pkg::ST_EXEC;
        end
      end
      idat_pkg::ST_EXEC: begin
        if (out_free) begin
          state_d = idat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = idat_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_d   = item_q;
    cnt_d    = cnt_q;
    pend_d   = 1'b0;
    pidx_d   = pidx_q;
    mfound_d = mfound_q;
    midx_d   = midx_q;
    efound_d = efound_q;
    eidx_d   = eidx_q;
    if ((state_q == idat_pkg::ST_IDLE) && in_valid_i) begin
      item_d   = in_item_i;
      cnt_d    = '0;
      mfound_d = 1'b0;
      midx_d   = '0;
      efound_d = 1'b0;
      eidx_d   = '0;
    end
    if (state_q == idat_pkg::ST_SCAN) begin
      if (issue) begin
        cnt_d  = cnt_q + idat_pkg::OCC_W'(1);
        pend_d = 1'b1;
        pidx_d = cnt_q[idat_pkg::SLOT_W-1:0];
      end
      if (eq) begin
        mfound_d = 1'b1;
        midx_d   = pidx_q;
        pend_d   = 1'b0;
      end else begin
        if (empty_now) begin
          efound_d = 1'b1;
          eidx_d   = pidx_q;
        end
        if (pend_q && last) begin
          pend_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.status     = idat_pkg::STATUS_OK;
    res.hit        = 1'b0;
    res.slot_index = '0;
    res.occupancy  = cur_fill;
    wr_want        = 1'b0;
    wr_cmd.set     = 1'b0;
    wr_cmd.addr    = eidx_q;
    wr_cmd.data    = $unsigned(item_q.entry_id);
    if (id_zero) begin
      res.status = idat_pkg::STATUS_ZERO;
    end else begin
      case (item_q.kind)
        idat_pkg::KIND_ADD: begin
          if (mfound_q) begin
            res.status     = idat_pkg::STATUS_PRESENT;
            res.hit        = 1'b1;
            res.slot_index = midx_q;
          end else if (!efound_q) begin
            res.status = idat_pkg::STATUS_FULL;
          end else begin
            res.slot_index = eidx_q;
            res.occupancy  = cur_fill + idat_pkg::OCC_W'(1);
            wr_want        = 1'b1;
            wr_cmd.set     = 1'b1;
          end
        end
        idat_pkg::KIND_DROP: begin
          if (!mfound_q) begin
            res.status = idat_pkg::STATUS_ABSENT;
          end else begin
            res.hit        = 1'b1;
            res.slot_index = midx_q;
            res.occupancy  = cur_fill - idat_pkg::OCC_W'(1);
            wr_want        = 1'b1;
            wr_cmd.addr    = midx_q;
          end
        end
        idat_pkg::KIND_LOOKUP: begin
          if (!mfound_q) begin
            res.status = idat_pkg::STATUS_ABSENT;
          end else begin
            res.hit        = 1'b1;
            res.slot_index = midx_q;
          end
        end
        default: begin
          if (!mfound_q) begin
            res.status = idat_pkg::STATUS_ABSENT;
          end else begin
            res.hit        = 1'b1;
            res.slot_index = midx_q;
          end
        end
      endcase
    end
    wr_cmd.en = commit && wr_want;
  end

  always_comb begin
    ord_wr     = wr_cmd;
    ord_wr.en  = wr_cmd.en && !item_q.table_select;
    priv_wr    = wr_cmd;
    priv_wr.en = wr_cmd.en && item_q.table_select;

    ord_fill_d  = ord_fill_q;
    priv_fill_d = priv_fill_q;
    if (wr_cmd.en) begin
      if (item_q.table_select) begin
        priv_fill_d = res.occupancy[idat_pkg::PRIV_FILL_W-1:0];
      end else begin
        ord_fill_d = res.occupancy;
      end
    end

    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (commit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idat_pkg::ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      mfound_q    <= 1'b0;
      efound_q    <= 1'b0;
      ord_fill_q  <= '0;
      priv_fill_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      mfound_q    <= mfound_d;
      efound_q    <= efound_d;
      ord_fill_q  <= ord_fill_d;
      priv_fill_q <= priv_fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pidx_q <= pidx_d;
    midx_q <= midx_d;
    eidx_q <= eidx_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != idat_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `IDAT_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != idat_pkg::ST_IDLE)
  `IDAT_ASSERT_IMPL(a_ord_fill_bound, 1'b1, ord_fill_q <= idat_pkg::OCC_W'(ORDINARY_SLOTS))
  `IDAT_ASSERT_IMPL(a_priv_fill_bound, 1'b1, {3'b000, priv_fill_q} <= idat_pkg::OCC_W'(PRIVILEGED_SLOTS))
  `IDAT_ASSERT_IMPL(a_write_only_on_commit, wr_cmd.en, (state_q == idat_pkg::ST_EXEC) && !id_zero)
  `IDAT_ASSERT_IMPL(a_zero_reports_no_slot, out_valid_o && (out_item_o.status == idat_pkg::STATUS_ZERO), !out_item_o.hit && (out_item_o.slot_index == '0))

endmodule

// ===== rtl/idat_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier slot store
// One table of identifier slots: a memory with one write and one registered
// read port, plus a per-slot occupied bit cleared by reset.
// ----------------------------------------------------------------------------
module idat_store #(
  parameter int unsigned DEPTH = idat_pkg::ORD_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [idat_pkg::SLOT_W-1:0] rd_addr_i,
  input  idat_pkg::wr_cmd_t           wr_i,
  output idat_pkg::rd_rsp_t           rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [idat_pkg::ID_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]          vld_q;
  logic [idat_pkg::ID_W-1:0] rdata_q;
  logic                      rvld_q;
  logic [AW-1:0]             rd_idx;
  logic [AW-1:0]             wr_idx;

  assign rd_idx = rd_addr_i[AW-1:0];
  assign wr_idx = wr_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.set) begin
      mem_q[wr_idx] <= wr_i.data;
    end
    rdata_q <= mem_q[rd_idx];
    rvld_q  <= vld_q[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_idx] <= wr_i.set;
    end
  end

  assign rsp_o.valid = rvld_q;
  assign rsp_o.data  = rdata_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier allowlist table testbench
// Drives add, drop and lookup items into both tables through a bursty sender
// while the result side stalls on its own pattern. A short directed table
// covers the field extremes, zero identifiers, duplicates and misses, then
// random phases fill, churn and drain the tables. Directed results are
// checked against the table, the rest against a local model of both tables.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ORD_SLOTS   = idat_pkg::ORD_SLOTS_DEF;
  localparam int PRIV_SLOTS  = idat_pkg::PRIV_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = ORD_SLOTS + 12;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 290;
  localparam int ORD_POOL    = 150;
  localparam int PRIV_POOL   = 22;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic       TBL_ORD    = 1'b0;
  localparam logic       TBL_PRIV   = 1'b1;

  localparam logic [63:0] ID_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ID_MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ID_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    idat_pkg::in_item_t  item;
    bit                  typed;
    idat_pkg::out_item_t result;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid = 1'b0;
  logic                in_stall;
  idat_pkg::in_item_t  in_item  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  idat_pkg::out_item_t out_item;

  logic [63:0] id_store [2][ORD_SLOTS];
  int          fill_count [2];
  logic [63:0] id_pool [2][ORD_POOL];

  idat_pkg::out_item_t awaited_results[$];
  idat_pkg::out_item_t oldest;
  stim_row_t           directed_rows[$];

  int failures        = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int status_seen [8];
  int burst_left      = 0;
  int stall_tick      = 0;
  int cycles          = 0;

  id_allowlist_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic idat_pkg::out_item_t next_response(input idat_pkg::in_item_t it);
    idat_pkg::out_item_t r;
    int                  sel;
    int                  size;
    int                  match;
    int                  empty;
    logic [63:0]         id;
    sel   = int'(it.table_select);
    size  = it.table_select ? PRIV_SLOTS : ORD_SLOTS;
    id    = it.entry_id;
    r     = '0;
    match = -1;
    empty = -1;
    r.status = idat_pkg::STATUS_OK;
    if (id == '0) begin
      r.status = idat_pkg::STATUS_ZERO;
    end else begin
      for (int i = 0; i < size; i++) begin
        if (match < 0 && id_store[sel][i] == id) begin
          match = i;
        end
      end
      if (it.kind == idat_pkg::KIND_ADD) begin
        if (match >= 0) begin
          r.status     = idat_pkg::STATUS_PRESENT;
          r.hit        = 1'b1;
          r.slot_index = idat_pkg::SLOT_W'(match);
        end else begin
          for (int i = 0; i < size; i++) begin
            if (id_store[sel][i] == '0) begin
              empty = i;
            end
          end
          if (empty < 0) begin
            r.status = idat_pkg::STATUS_FULL;
          end else begin
            id_store[sel][empty] = id;
            fill_count[sel]++;
            r.slot_index = idat_pkg::SLOT_W'(empty);
          end
        end
      end else if (match < 0) begin
        r.status = idat_pkg::STATUS_ABSENT;
      end else begin
        if (it.kind == idat_pkg::KIND_DROP) begin
          id_store[sel][match] = '0;
          if (fill_count[sel] > 0) begin
            fill_count[sel]--;
          end
        end
        r.hit        = 1'b1;
        r.slot_index = idat_pkg::SLOT_W'(match);
      end
    end
    r.occupancy = idat_pkg::OCC_W'(fill_count[sel]);
    return r;
  endfunction

  function automatic stim_row_t stim_row(input logic [1:0] kind, input logic tsel,
                                         input logic [63:0] id, input idat_pkg::status_e st,
                                         input logic hit, input int slot, input int occ);
    stim_row_t row;
    row.item.kind          = kind;
    row.item.table_select  = tsel;
    row.item.entry_id      = id;
    row.typed              = 1'b1;
    row.result.status      = st;
    row.result.hit         = hit;
    row.result.slot_index  = idat_pkg::SLOT_W'(slot);
    row.result.occupancy   = idat_pkg::OCC_W'(occ);
    return row;
  endfunction

  function automatic idat_pkg::in_item_t random_item(input int add_pct, input int ord_pct);
    idat_pkg::in_item_t it;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) begin
      it.kind = idat_pkg::KIND_ADD;
    end else if (pick < add_pct + (100 - add_pct) / 2) begin
      it.kind = idat_pkg::KIND_DROP;
    end else if ($urandom_range(0, 9) == 0) begin
      it.kind = KIND_SPARE;
    end else begin
      it.kind = idat_pkg::KIND_LOOKUP;
    end
    it.table_select = ($urandom_range(0, 99) >= ord_pct) ? TBL_PRIV : TBL_ORD;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      it.entry_id = '0;
    end else if (pick < 8) begin
      it.entry_id = {$urandom, $urandom};
    end else if (it.table_select == TBL_PRIV) begin
      it.entry_id = id_pool[1][$urandom_range(0, PRIV_POOL - 1)];
    end else begin
      it.entry_id = id_pool[0][$urandom_range(0, ORD_POOL - 1)];
    end
    return it;
  endfunction

  task automatic send_item(input idat_pkg::in_item_t it, input bit typed,
                           input idat_pkg::out_item_t typed_result);
    int                  gap;
    idat_pkg::out_item_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    burst_left--;
    items_sent++;
    predicted = next_response(it);
    awaited_results.push_back(typed ? typed_result : predicted);
  endtask

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick / 300) % 4)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 40);
      2:       out_stall <= ((stall_tick % 7) < 3);
      default: out_stall <= ($urandom_range(0, 99) < 80);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with no pending item: status %0d slot %0d", out_item.status,
               out_item.slot_index);
        failures++;
      end else begin
        oldest = awaited_results.pop_front();
        results_checked++;
        status_seen[out_item.status]++;
        if (out_item.status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_item.status);
          failures++;
        end
        if (out_item.hit !== oldest.hit) begin
          $error("hit: expected %0d, got %0d", oldest.hit, out_item.hit);
          failures++;
        end
        if (out_item.slot_index !== oldest.slot_index) begin
          $error("slot_index: expected %0d, got %0d", oldest.slot_index,
                 out_item.slot_index);
          failures++;
        end
        if (out_item.occupancy !== oldest.occupancy) begin
          $error("occupancy: expected %0d, got %0d", oldest.occupancy, out_item.occupancy);
          failures++;
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int add_pct [PHASES];
    int ord_pct [PHASES];
    add_pct = '{85, 85, 45, 15, 80, 40};
    ord_pct = '{75, 75, 60, 60, 50, 50};
    for (int t = 0; t < 2; t++) begin
      fill_count[t] = 0;
      for (int i = 0; i < ORD_SLOTS; i++) begin
        id_store[t][i] = '0;
      end
      for (int i = 0; i < ORD_POOL; i++) begin
        id_pool[t][i] = {$urandom, $urandom};
        if (id_pool[t][i] == '0) begin
          id_pool[t][i] = 64'd1;
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      status_seen[i] = 0;
    end

    directed_rows.push_back(stim_row(idat_pkg::KIND_LOOKUP, TBL_ORD, '0,
                                     idat_pkg::STATUS_ZERO, 1'b0, 0, 0));
    directed_rows.push_back(stim_row(idat_pkg::KIND_ADD, TBL_ORD, 64'd1,
                                     idat_pkg::STATUS_OK, 1'b0, 127, 1));
    directed_rows.push_back(stim_row(idat_pkg::KIND_ADD, TBL_ORD, ID_MAX_POS,
                                     idat_pkg::STATUS_OK, 1'b0, 126, 2));
    directed_rows.push_back(stim_row(idat_pkg::KIND_ADD, TBL_ORD, ID_MIN_NEG,
                                     idat_pkg::STATUS_OK, 1'b0, 125, 3));
    directed_rows.push_back(stim_row(idat_pkg::KIND_ADD, TBL_ORD, ID_ONES,
                                     idat_pkg::STATUS_OK, 1'b0, 124, 4));
    directed_rows.push_back(stim_row(idat_pkg::KIND_ADD, TBL_ORD, 64'd1,
                                     idat_pkg::STATUS_PRESENT, 1'b1, 127, 4));
    directed_rows.push_back(stim_row(idat_pkg::KIND_LOOKUP, TBL_ORD, ID_MIN_NEG,
                                     idat_pkg::STATUS_OK, 1'b1, 125, 4));
    directed_rows.push_back(stim_row(KIND_SPARE, TBL_ORD, ID_MAX_POS,
                                     idat_pkg::STATUS_OK, 1'b1, 126, 4));
    directed_rows.push_back(stim_row(idat_pkg::KIND_DROP, TBL_ORD, 64'd1,
                                     idat_pkg::STATUS_OK, 1'b1, 127, 3));
    directed_rows.push_back(stim_row(idat_pkg::KIND_DROP, TBL_ORD, 64'd1,
                                     idat_pkg::STATUS_ABSENT, 1'b0, 0, 3));
    directed_rows.push_back(stim_row(idat_pkg::KIND_LOOKUP, TBL_ORD, 64'd1,
                                     idat_pkg::STATUS_ABSENT, 1'b0, 0, 3));
    directed_rows.push_back(stim_row(idat_pkg::KIND_ADD, TBL_ORD, '0,
                                     idat_pkg::STATUS_ZERO, 1'b0, 0, 3));
    directed_rows.push_back(stim_row(idat_pkg::KIND_DROP, TBL_ORD, '0,
                                     idat_pkg::STATUS_ZERO, 1'b0, 0, 3));
    directed_rows.push_back(stim_row(idat_pkg::KIND_ADD, TBL_ORD, 64'h5555_5555_5555_5555,
                                     idat_pkg::STATUS_OK, 1'b0, 127, 4));
    directed_rows.push_back(stim_row(idat_pkg::KIND_ADD, TBL_PRIV, ID_ONES,
                                     idat_pkg::STATUS_OK, 1'b0, 15, 1));
    directed_rows.push_back(stim_row(idat_pkg::KIND_LOOKUP, TBL_PRIV, ID_MAX_POS,
                                     idat_pkg::STATUS_ABSENT, 1'b0, 0, 1));
    directed_rows.push_back(stim_row(idat_pkg::KIND_DROP, TBL_PRIV, ID_ONES,
                                     idat_pkg::STATUS_OK, 1'b1, 15, 0));
    directed_rows.push_back(stim_row(idat_pkg::KIND_LOOKUP, TBL_PRIV, '0,
                                     idat_pkg::STATUS_ZERO, 1'b0, 0, 0));
    directed_rows.push_back(stim_row(idat_pkg::KIND_ADD, TBL_PRIV, 64'hAAAA_AAAA_AAAA_AAAA,
                                     idat_pkg::STATUS_OK, 1'b0, 15, 1));
    directed_rows.push_back(stim_row(KIND_SPARE, TBL_PRIV, 64'hAAAA_AAAA_AAAA_AAAA,
                                     idat_pkg::STATUS_OK, 1'b1, 15, 1));
    directed_rows.push_back(stim_row(idat_pkg::KIND_DROP, TBL_ORD, ID_ONES,
                                     idat_pkg::STATUS_OK, 1'b1, 124, 3));

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end

    for (int p = 0; p < PHASES; p++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item(add_pct[p], ord_pct[p]), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d items and checked %0d results in %0d cycles.", items_sent,
             results_checked, cycles);
    $display("Statuses seen: ok %0d, zero id %0d, present %0d, full %0d, not found %0d.",
             status_seen[idat_pkg::STATUS_OK], status_seen[idat_pkg::STATUS_ZERO],
             status_seen[idat_pkg::STATUS_PRESENT], status_seen[idat_pkg::STATUS_FULL],
             status_seen[idat_pkg::STATUS_ABSENT]);
    if (failures == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
